[hw/rtl/hssf_pkg.sv]
// Shared constants, microcode format and control program for the head-shadow stereo filter.
`timescale 1ns / 1ps
`default_nettype none
package hssf_pkg;

   // Default parameter values
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // Coefficient registers are fixed signed Q3.16 words
   localparam int COEF_WIDTH = 20;
   localparam int CSR_ADDR_W = 3;

   // Intermediate value s is clamped to +-(2^43-1) and multiplied in two halves
   localparam int MID_BITS    = 44;
   localparam int MID_LO_BITS = 22;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_INV_A0   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_A1_COEF  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_B0_LEFT  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_B1_LEFT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_B0_RIGHT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_B1_RIGHT = 3'd5;

   // Reset values: azimuth 0 at 44.1 kHz
   localparam logic signed [COEF_WIDTH-1:0] RST_INV_A0   = 20'sd30114;
   localparam logic signed [COEF_WIDTH-1:0] RST_A1_COEF  = -20'sd119521;
   localparam logic signed [COEF_WIDTH-1:0] RST_B0_LEFT  = 20'sd142625;
   localparam logic signed [COEF_WIDTH-1:0] RST_B1_LEFT  = -20'sd119521;
   localparam logic signed [COEF_WIDTH-1:0] RST_B0_RIGHT = 20'sd142625;
   localparam logic signed [COEF_WIDTH-1:0] RST_B1_RIGHT = -20'sd119521;

   // Program length and step counter width
   localparam int STEP_COUNT = 19;
   localparam int PC_W       = 5;

   // Jump conditions
   localparam logic [1:0] JMP_NONE     = 2'd0;
   localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
   localparam logic [1:0] JMP_WAIT_OUT = 2'd2;

   // Multiplier coefficient operand
   localparam logic [2:0] MA_B0L = 3'd0;
   localparam logic [2:0] MA_B1L = 3'd1;
   localparam logic [2:0] MA_B0R = 3'd2;
   localparam logic [2:0] MA_B1R = 3'd3;
   localparam logic [2:0] MA_A1  = 3'd4;
   localparam logic [2:0] MA_INV = 3'd5;

   // Multiplier sample operand
   localparam logic [2:0] MB_X   = 3'd0;
   localparam logic [2:0] MB_XP  = 3'd1;
   localparam logic [2:0] MB_YL  = 3'd2;
   localparam logic [2:0] MB_YR  = 3'd3;
   localparam logic [2:0] MB_SLO = 3'd4;
   localparam logic [2:0] MB_SHI = 3'd5;

   // Accumulator operations on the registered product
   localparam logic [2:0] ACC_NOP    = 3'd0;
   localparam logic [2:0] ACC_LOAD   = 3'd1;
   localparam logic [2:0] ACC_ADD    = 3'd2;
   localparam logic [2:0] ACC_SUB    = 3'd3;
   localparam logic [2:0] ACC_ADD_HI = 3'd4;

   // Ear output write
   localparam logic [1:0] YW_NONE  = 2'd0;
   localparam logic [1:0] YW_LEFT  = 2'd1;
   localparam logic [1:0] YW_RIGHT = 2'd2;

   typedef struct packed {
      logic [1:0] jump;
      logic       last;
      logic       mul_en;
      logic [2:0] mul_a;
      logic [2:0] mul_b;
      logic [2:0] acc_op;
      logic       s_wr;
      logic [1:0] y_wr;
   } step_word_type;

   // Control word with the handshake events of this cycle
   typedef struct packed {
      step_word_type word;
      logic          take;
      logic          emit;
   } ctrl_type;

   function automatic step_word_type mk_step(input logic [1:0] jump, input logic last,
                                             input logic mul_en, input logic [2:0] mul_a,
                                             input logic [2:0] mul_b, input logic [2:0] acc_op,
                                             input logic s_wr, input logic [1:0] y_wr);
      step_word_type w;
      w.jump   = jump;
      w.last   = last;
      w.mul_en = mul_en;
      w.mul_a  = mul_a;
      w.mul_b  = mul_b;
      w.acc_op = acc_op;
      w.s_wr   = s_wr;
      w.y_wr   = y_wr;
      return w;
   endfunction

   // Control program: the product of a step is accumulated by the next step
   function automatic step_word_type hssf_microcode(input logic [PC_W-1:0] pc);
      step_word_type w;
      unique case (pc)
         5'd0:  w = mk_step(JMP_WAIT_IN, 1'b0, 1'b0, MA_B0L, MB_X, ACC_NOP, 1'b0, YW_NONE);
         // left ear numerator
         5'd1:  w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_B0L, MB_X, ACC_NOP, 1'b0, YW_NONE);
         5'd2:  w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_B1L, MB_XP, ACC_LOAD, 1'b0, YW_NONE);
         5'd3:  w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_A1, MB_YL, ACC_ADD, 1'b0, YW_NONE);
         5'd4:  w = mk_step(JMP_NONE, 1'b0, 1'b0, MA_A1, MB_YL, ACC_SUB, 1'b0, YW_NONE);
         5'd5:  w = mk_step(JMP_NONE, 1'b0, 1'b0, MA_INV, MB_X, ACC_NOP, 1'b1, YW_NONE);
         // left ear scale by 1/a0
         5'd6:  w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_INV, MB_SLO, ACC_NOP, 1'b0, YW_NONE);
         5'd7:  w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_INV, MB_SHI, ACC_LOAD, 1'b0, YW_NONE);
         5'd8:  w = mk_step(JMP_NONE, 1'b0, 1'b0, MA_INV, MB_X, ACC_ADD_HI, 1'b0, YW_NONE);
         // left result, right ear starts
         5'd9:  w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_B0R, MB_X, ACC_NOP, 1'b0, YW_LEFT);
         5'd10: w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_B1R, MB_XP, ACC_LOAD, 1'b0, YW_NONE);
         5'd11: w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_A1, MB_YR, ACC_ADD, 1'b0, YW_NONE);
         5'd12: w = mk_step(JMP_NONE, 1'b0, 1'b0, MA_A1, MB_YR, ACC_SUB, 1'b0, YW_NONE);
         5'd13: w = mk_step(JMP_NONE, 1'b0, 1'b0, MA_INV, MB_X, ACC_NOP, 1'b1, YW_NONE);
         5'd14: w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_INV, MB_SLO, ACC_NOP, 1'b0, YW_NONE);
         5'd15: w = mk_step(JMP_NONE, 1'b0, 1'b1, MA_INV, MB_SHI, ACC_LOAD, 1'b0, YW_NONE);
         5'd16: w = mk_step(JMP_NONE, 1'b0, 1'b0, MA_INV, MB_X, ACC_ADD_HI, 1'b0, YW_NONE);
         5'd17: w = mk_step(JMP_NONE, 1'b0, 1'b0, MA_INV, MB_X, ACC_NOP, 1'b0, YW_RIGHT);
         // hand the stereo pair to the output register
         5'd18: w = mk_step(JMP_WAIT_OUT, 1'b1, 1'b0, MA_INV, MB_X, ACC_NOP, 1'b0, YW_NONE);
         default: w = mk_step(JMP_NONE, 1'b1, 1'b0, MA_INV, MB_X, ACC_NOP, 1'b0, YW_NONE);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/head_shadow_stereo_filter_unit.sv]
// Top level of the first-order head-shadow stereo filter.
`timescale 1ns / 1ps
`default_nettype none
// Takes one signed mono sample per request and returns a left and a right sample, each from
// y = inv_a0 * (b0*x + b1*x_prev - a1*y_prev) with signed Q3.16 coefficients, rounded half up
// and saturated to the sample range; rsp_tuser flags a saturated pair. A request is accepted
// in the idle step and its result enters the output register from the last step; a microcoded
// sequence of nine steps per ear drives a single shared coefficient multiplier, whose product
// is registered before it is accumulated. The next request is accepted while a finished result
// still waits in the output register; a second finished result holds the sequence on its last
// step until the first one is taken. No request is accepted while reset is held. The user must
// write coefficients through the csr port only while the block is idle; the block leaves this
// to the user. Indexes 6 and 7 are ignored.
module head_shadow_stereo_filter_unit #(
   parameter int SAMPLE_BITS    = hssf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = hssf_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,  // mono_sample
   // Result channel
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,  // left_sample, right_sample
   output logic                                       rsp_tuser,  // clipped
   // Coefficient registers
   input  wire logic                                  csr_wen,
   input  wire logic [hssf_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [hssf_pkg::COEF_WIDTH-1:0]       csr_wdata
);
   import hssf_pkg::*;

   localparam int RSP_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   ctrl_type               ctrl;
   logic                   out_free;
   logic [SAMPLE_BITS-1:0] out_left, out_right;

   hssf_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   hssf_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .in_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .out_left   (out_left),
      .out_right  (out_right),
      .out_clip   (rsp_tuser)
   );

   // Pack the stereo pair, left in the low bits
   assign rsp_tdata = RSP_W'({out_right, out_left});

endmodule
`default_nettype wire

[hw/rtl/hssf_sequencer.sv]
// Step counter and control store that sequence the filter datapath.
`timescale 1ns / 1ps
`default_nettype none
module hssf_sequencer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               out_free,
   output logic                    req_tready,
   output hssf_pkg::ctrl_type      ctrl
);
   import hssf_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   step_word_type   word;
   logic            hold;

   // Fetch the control word of the current step
   assign word = hssf_microcode(pc_ff);

   // Refuse requests while reset is held
   assign req_tready = (word.jump == JMP_WAIT_IN) && !reset;

   // Evaluate the jump condition: stay on a waiting step
   always_comb begin
      unique case (word.jump)
         JMP_WAIT_IN:  hold = !req_tvalid;
         JMP_WAIT_OUT: hold = !out_free;
         default:      hold = 1'b0;
      endcase
   end

   always_comb begin
      ctrl.word = word;
      ctrl.take = req_tready && req_tvalid;
      ctrl.emit = (word.jump == JMP_WAIT_OUT) && out_free;
   end

   // Advance, hold or restart the program
   always_comb begin
      priority if (hold) begin
         pc_in = pc_ff;
      end else if (word.last) begin
         pc_in = '0;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/hssf_datapath.sv]
// Coefficient registers, shared multiplier, accumulator, rounding and filter state.
`timescale 1ns / 1ps
`default_nettype none
module hssf_datapath #(
   parameter int SAMPLE_BITS    = hssf_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = hssf_pkg::COEF_FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire hssf_pkg::ctrl_type                    ctrl,
   input  wire logic [SAMPLE_BITS-1:0]                in_sample,
   input  wire logic                                  csr_wen,
   input  wire logic [hssf_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [hssf_pkg::COEF_WIDTH-1:0]       csr_wdata,
   input  wire logic                                  rsp_tready,
   output logic                                       out_free,
   output logic                                       rsp_tvalid,
   output logic [SAMPLE_BITS-1:0]                     out_left,
   output logic [SAMPLE_BITS-1:0]                     out_right,
   output logic                                       out_clip
);
   import hssf_pkg::*;

   localparam int MB     = (SAMPLE_BITS > MID_LO_BITS + 1) ? SAMPLE_BITS : MID_LO_BITS + 1;
   localparam int PROD_W = COEF_WIDTH + MB;
   localparam int ACC_P1 = COEF_WIDTH + SAMPLE_BITS + 3;
   localparam int ACC_P2 = COEF_WIDTH + MID_BITS + 2;
   localparam int ACC_W  = (ACC_P1 > ACC_P2) ? ACC_P1 : ACC_P2;

   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] MID_MAX = (ACC_W'(1) <<< (MID_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] MID_MIN = -MID_MAX;
   localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   // Coefficient registers
   logic signed [COEF_WIDTH-1:0] inv_a0_ff, a1_coef_ff;
   logic signed [COEF_WIDTH-1:0] b0_left_ff, b1_left_ff, b0_right_ff, b1_right_ff;

   // Filter state and work registers
   logic signed [SAMPLE_BITS-1:0] x_ff, xp_ff, yl_ff, yr_ff;
   logic signed [MID_BITS-1:0]    s_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          clip_ff;

   // Output register
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_left_ff, rsp_right_ff;
   logic                          rsp_clip_ff;

   logic signed [COEF_WIDTH-1:0]  a_op;
   logic signed [MB-1:0]          b_op;
   logic signed [MID_BITS-MID_LO_BITS-1:0] s_hi;
   logic signed [ACC_W-1:0]       prod_ext;
   logic signed [ACC_W-1:0]       rnd_sum, rnd_q;
   logic signed [ACC_W-1:0]       s_clamp, y_clamp;
   logic                          y_sat;

   // Load coefficients from the register port; ignore unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_a0_ff   <= RST_INV_A0;
         a1_coef_ff  <= RST_A1_COEF;
         b0_left_ff  <= RST_B0_LEFT;
         b1_left_ff  <= RST_B1_LEFT;
         b0_right_ff <= RST_B0_RIGHT;
         b1_right_ff <= RST_B1_RIGHT;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_INV_A0:   inv_a0_ff   <= csr_wdata;
            REG_A1_COEF:  a1_coef_ff  <= csr_wdata;
            REG_B0_LEFT:  b0_left_ff  <= csr_wdata;
            REG_B1_LEFT:  b1_left_ff  <= csr_wdata;
            REG_B0_RIGHT: b0_right_ff <= csr_wdata;
            REG_B1_RIGHT: b1_right_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Select multiplier operands
   assign s_hi = s_ff[MID_BITS-1:MID_LO_BITS];

   always_comb begin
      unique case (ctrl.word.mul_a)
         MA_B0L:  a_op = b0_left_ff;
         MA_B1L:  a_op = b1_left_ff;
         MA_B0R:  a_op = b0_right_ff;
         MA_B1R:  a_op = b1_right_ff;
         MA_A1:   a_op = a1_coef_ff;
         default: a_op = inv_a0_ff;
      endcase
   end

   always_comb begin
      unique case (ctrl.word.mul_b)
         MB_XP:   b_op = MB'(xp_ff);
         MB_YL:   b_op = MB'(yl_ff);
         MB_YR:   b_op = MB'(yr_ff);
         MB_SLO:  b_op = MB'({1'b0, s_ff[MID_LO_BITS-1:0]});
         MB_SHI:  b_op = MB'(s_hi);
         default: b_op = MB'(x_ff);
      endcase
   end

   assign prod_in  = a_op * b_op;
   assign prod_ext = ACC_W'(prod_ff);

   // Accumulate the product registered by the previous step
   always_comb begin
      unique case (ctrl.word.acc_op)
         ACC_LOAD:   acc_in = prod_ext;
         ACC_ADD:    acc_in = acc_ff + prod_ext;
         ACC_SUB:    acc_in = acc_ff - prod_ext;
         ACC_ADD_HI: acc_in = acc_ff + (prod_ext <<< MID_LO_BITS);
         default:    acc_in = acc_ff;
      endcase
   end

   // Round half up, then clamp to the intermediate range and to the sample range
   assign rnd_sum = acc_ff + HALF;
   assign rnd_q   = rnd_sum >>> COEF_FRAC_BITS;

   always_comb begin
      s_clamp = rnd_q;
      if (rnd_q > MID_MAX) begin
         s_clamp = MID_MAX;
      end
      if (rnd_q < MID_MIN) begin
         s_clamp = MID_MIN;
      end
      y_clamp = rnd_q;
      y_sat   = 1'b0;
      if (rnd_q > SAT_MAX) begin
         y_clamp = SAT_MAX;
         y_sat   = 1'b1;
      end
      if (rnd_q < SAT_MIN) begin
         y_clamp = SAT_MIN;
         y_sat   = 1'b1;
      end
   end

   // Work registers
   always_ff @(posedge clock) begin
      if (ctrl.word.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (ctrl.word.s_wr) begin
         s_ff <= s_clamp[MID_BITS-1:0];
      end
      if (ctrl.take) begin
         x_ff <= in_sample;
      end
   end

   // Filter state and clip flag
   always_ff @(posedge clock) begin
      if (reset) begin
         xp_ff   <= '0;
         yl_ff   <= '0;
         yr_ff   <= '0;
         clip_ff <= 1'b0;
      end else begin
         if (ctrl.take) begin
            clip_ff <= 1'b0;
         end else if (ctrl.word.y_wr != YW_NONE) begin
            clip_ff <= clip_ff | y_sat;
         end
         if (ctrl.word.y_wr == YW_LEFT) begin
            yl_ff <= y_clamp[SAMPLE_BITS-1:0];
         end
         if (ctrl.word.y_wr == YW_RIGHT) begin
            yr_ff <= y_clamp[SAMPLE_BITS-1:0];
         end
         if (ctrl.emit) begin
            xp_ff <= x_ff;
         end
      end
   end

   // Output register: load on emit, drop on take
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_left_ff  <= yl_ff;
         rsp_right_ff <= yr_ff;
         rsp_clip_ff  <= clip_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_left   = rsp_left_ff;
   assign out_right  = rsp_right_ff;
   assign out_clip   = rsp_clip_ff;

endmodule
`default_nettype wire

[hw/rtl/hssf_checker.sv]
// Port-level checks for the head-shadow stereo filter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module hssf_checker #(
   parameter int SAMPLE_BITS = hssf_pkg::SAMPLE_BITS_DEF
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  rsp_tdata,
   input wire logic                                rsp_tuser
);
   localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [SAMPLE_BITS-1:0] left_s, right_s;

   assign left_s  = rsp_tdata[SAMPLE_BITS-1:0];
   assign right_s = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // One sample at a time: ready drops right after a request is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous sample in progress");

   // A result never appears the cycle after a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result too early after request");

   // The clip flag implies a sample at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (left_s == S_MAX) || (left_s == S_MIN) ||
                                  (right_s == S_MAX) || (right_s == S_MIN))
      else $error("clip flag without a saturated sample");

endmodule

bind head_shadow_stereo_filter_unit hssf_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_hssf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
